[rtl/gcb_pkg.sv]
// Shared types and constants of the glyph cell blitter.
// Used by the top level; depends on nothing else.
package gcb_pkg;

   localparam int CELL_COLS = 8;
   localparam int X_W       = 16;
   localparam int LINE_W    = 17;
   localparam int INDEX_W   = 29;
   localparam int PROD_W    = 30;
   localparam int GADDR_W   = 14;
   localparam int COLOR_W   = 32;
   localparam int CODE_W    = 8;
   localparam int FADDR_W   = 13;
   localparam int SCREEN_W  = 13;
   localparam int GH_W      = 6;
   localparam int PADDR_W   = 4;
   localparam int PDATA_W   = 32;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_GLYPH_HEIGHT  = 2'd2;

   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 13'd768;
   localparam logic [GH_W-1:0]     GLYPH_HEIGHT_RESET  = 6'd16;

   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] index;
      logic [LINE_W-1:0]  line;
      logic               last;
      logic               out_of_store;
   } row_type;

endpackage

[rtl/gcb_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module gcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/glyph_cell_blitter.sv]
// Top level of the glyph cell blitter: command port, register file, draw sequencer.
// Depends on gcb_pkg and gcb_ram.
//
// A load command writes one font byte into the glyph memory; busy stays low. A draw command
// raises busy through ST_MUL, which does the glyph and line multiplies, ST_BASE, which forms
// the first pixel index, ST_ROWS, which reads the glyph memory for each drawn row, and the
// read latency held in stage_ff. The single read port of the glyph memory sets the pace of
// one row per cycle. Each row beat appears on the rsp_ ports for one cycle with rsp_strobe
// high, after its memory read has passed the registered read data and the out_ registers;
// the receiver cannot stall, so it must take every beat as it comes.
module glyph_cell_blitter #(
   parameter int GLYPH_STORE_DEPTH = 8192,
   parameter int CELL_ROWS         = 12,
   parameter int SKIP_ROWS         = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic [gcb_pkg::FADDR_W-1:0]       req_font_addr,
   input  logic [7:0]                        req_font_byte,
   input  logic [gcb_pkg::X_W-1:0]           req_cell_x,
   input  logic [gcb_pkg::X_W-1:0]           req_cell_y,
   input  logic [gcb_pkg::COLOR_W-1:0]       req_ink_color,
   input  logic [gcb_pkg::CODE_W-1:0]        req_char_code,
   output logic                              rsp_strobe,
   output logic [gcb_pkg::INDEX_W-1:0]       rsp_row_base_index,
   output logic [gcb_pkg::CELL_COLS-1:0]     rsp_pixel_mask,
   output logic [gcb_pkg::COLOR_W-1:0]       rsp_write_color,
   output logic                              rsp_last_row,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gcb_pkg::PADDR_W-1:0]       paddr,
   input  logic [gcb_pkg::PDATA_W-1:0]       pwdata,
   output logic [gcb_pkg::PDATA_W-1:0]       prdata,
   output logic                              pready
);
   import gcb_pkg::*;

   localparam int  AW       = $clog2(GLYPH_STORE_DEPTH);
   localparam int  RW       = $clog2(CELL_ROWS);
   localparam bit  HAS_ROWS = CELL_ROWS > SKIP_ROWS;
   localparam logic [RW-1:0]     FIRST_ROW = RW'(SKIP_ROWS);
   localparam logic [RW-1:0]     LAST_ROW  = RW'(CELL_ROWS - 1);
   localparam logic [GADDR_W:0]  DEPTH_LIM = (GADDR_W + 1)'(GLYPH_STORE_DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_BASE, ST_ROWS} state_type;

   state_type             state_ff;
   logic [SCREEN_W-1:0]   screen_width_ff;
   logic [SCREEN_W-1:0]   screen_height_ff;
   logic [GH_W-1:0]       glyph_height_ff;
   logic [X_W-1:0]        x_ff;
   logic [X_W-1:0]        y_ff;
   logic [COLOR_W-1:0]    color_ff;
   logic [CODE_W-1:0]     code_ff;
   logic [GADDR_W-1:0]    glyph_base_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [INDEX_W-1:0]    index_ff;
   logic [LINE_W-1:0]     line_ff;
   logic [RW-1:0]         row_ff;
   logic [CELL_COLS-1:0]  col_mask_ff;
   row_type               stage_ff;
   logic                  strobe_ff;
   logic [INDEX_W-1:0]    out_index_ff;
   logic [CELL_COLS-1:0]  out_mask_ff;
   logic [COLOR_W-1:0]    out_color_ff;
   logic                  out_last_ff;

   logic                  accept;
   logic                  csr_write;
   logic                  load_en;
   logic [GADDR_W-1:0]    glyph_addr;
   logic                  glyph_oob;
   logic [AW-1:0]         rd_addr;
   logic [7:0]            rd_data;
   logic [LINE_W-1:0]     first_line;
   logic [CELL_COLS-1:0]  col_mask;

   assign busy      = (state_ff != ST_IDLE) || stage_ff.valid;
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         glyph_height_ff  <= GLYPH_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            CSR_SCREEN_WIDTH:  screen_width_ff  <= pwdata[SCREEN_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= pwdata[SCREEN_W-1:0];
            CSR_GLYPH_HEIGHT:  glyph_height_ff  <= pwdata[GH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         CSR_SCREEN_WIDTH:  prdata = PDATA_W'(screen_width_ff);
         CSR_SCREEN_HEIGHT: prdata = PDATA_W'(screen_height_ff);
         CSR_GLYPH_HEIGHT:  prdata = PDATA_W'(glyph_height_ff);
         default:           prdata = '0;
      endcase
   end

   assign load_en    = accept && (req_op == OP_LOAD)
                       && ({1'b0, (GADDR_W)'(req_font_addr)} < DEPTH_LIM);
   assign glyph_addr = GADDR_W'(glyph_base_ff + GADDR_W'(row_ff));
   assign glyph_oob  = {1'b0, glyph_addr} >= DEPTH_LIM;
   assign rd_addr    = glyph_oob ? '0 : AW'(glyph_addr);
   assign first_line = LINE_W'(y_ff) + LINE_W'(SKIP_ROWS);

   always_comb begin
      for (int k = 0; k < CELL_COLS; k++) begin
         col_mask[CELL_COLS-1-k] = (LINE_W'(x_ff) + LINE_W'(k)) < LINE_W'(screen_width_ff);
      end
   end

   gcb_ram #(
      .WIDTH (8),
      .DEPTH (GLYPH_STORE_DEPTH)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (AW'(req_font_addr)),
      .wr_data (req_font_byte),
      .rd_en   (state_ff == ST_ROWS),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         stage_ff.valid <= 1'b0;
         strobe_ff      <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_op == OP_DRAW) && HAS_ROWS) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL:  state_ff <= ST_BASE;
            ST_BASE: state_ff <= ST_ROWS;
            ST_ROWS: begin
               if (row_ff == LAST_ROW) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         stage_ff.valid <= (state_ff == ST_ROWS);
         strobe_ff      <= stage_ff.valid;
      end

      if (accept) begin
         x_ff     <= req_cell_x;
         y_ff     <= req_cell_y;
         color_ff <= req_ink_color;
         code_ff  <= req_char_code;
      end

      if (state_ff == ST_MUL) begin
         glyph_base_ff <= GADDR_W'(code_ff * glyph_height_ff);
         prod_ff       <= PROD_W'(first_line * screen_width_ff);
         line_ff       <= first_line;
         col_mask_ff   <= col_mask;
      end

      if (state_ff == ST_BASE) begin
         index_ff <= INDEX_W'(prod_ff[INDEX_W-1:0] + INDEX_W'(x_ff));
         row_ff   <= FIRST_ROW;
      end

      if (state_ff == ST_ROWS) begin
         stage_ff.index        <= index_ff;
         stage_ff.line         <= line_ff;
         stage_ff.last         <= (row_ff == LAST_ROW);
         stage_ff.out_of_store <= glyph_oob;
         index_ff              <= INDEX_W'(index_ff + INDEX_W'(screen_width_ff));
         line_ff               <= LINE_W'(line_ff + 1'b1);
         row_ff                <= RW'(row_ff + 1'b1);
      end

      if (stage_ff.valid) begin
         out_index_ff <= stage_ff.index;
         out_color_ff <= color_ff;
         out_last_ff  <= stage_ff.last;
         if (stage_ff.out_of_store || (stage_ff.line >= LINE_W'(screen_height_ff))) begin
            out_mask_ff <= '0;
         end else begin
            out_mask_ff <= rd_data & col_mask_ff;
         end
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_row_base_index = out_index_ff;
   assign rsp_pixel_mask     = out_mask_ff;
   assign rsp_write_color    = out_color_ff;
   assign rsp_last_row       = out_last_ff;

endmodule

[tb/sv/glyph_row_checker.sv]
`timescale 1ns / 100ps
// Row checker for the glyph cell blitter: watches the command, row and register ports,
// predicts the row beats of every draw and compares them as they arrive. Depends on gcb_pkg.
module glyph_row_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_op,
   input  logic [gcb_pkg::FADDR_W-1:0]   req_font_addr,
   input  logic [7:0]                    req_font_byte,
   input  logic [gcb_pkg::X_W-1:0]       req_cell_x,
   input  logic [gcb_pkg::X_W-1:0]       req_cell_y,
   input  logic [gcb_pkg::COLOR_W-1:0]   req_ink_color,
   input  logic [gcb_pkg::CODE_W-1:0]    req_char_code,
   input  logic                          rsp_strobe,
   input  logic [gcb_pkg::INDEX_W-1:0]   rsp_row_base_index,
   input  logic [gcb_pkg::CELL_COLS-1:0] rsp_pixel_mask,
   input  logic [gcb_pkg::COLOR_W-1:0]   rsp_write_color,
   input  logic                          rsp_last_row,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [gcb_pkg::PADDR_W-1:0]   paddr,
   input  logic [gcb_pkg::PDATA_W-1:0]   pwdata,
   input  logic                          pready,
   output int                            mismatch_count,
   output int                            rows_outstanding
);
   import gcb_pkg::*;

   localparam int FONT_DEPTH    = 8192;
   localparam int FIRST_ROW     = 2;
   localparam int ROWS_PER_CELL = 12;

   typedef struct packed {
      logic [INDEX_W-1:0]   index;
      logic [CELL_COLS-1:0] mask;
      logic [COLOR_W-1:0]   color;
      logic                 last;
   } row_beat_type;

   logic [7:0]          font_mem [FONT_DEPTH];
   logic [SCREEN_W-1:0] width_reg;
   logic [SCREEN_W-1:0] height_reg;
   logic [GH_W-1:0]     glyph_height_reg;
   row_beat_type        rows_due [$];
   row_beat_type        want;
   int                  beat_no;

   task automatic report_mismatch(input string msg);
      $display("[%0t] row beat %0d: %s", $time, beat_no, msg);
      mismatch_count++;
   endtask

   function automatic void predict_draw_rows(input logic [X_W-1:0] x, input logic [X_W-1:0] y,
                                             input logic [COLOR_W-1:0] color,
                                             input logic [CODE_W-1:0] code);
      row_beat_type    beat;
      longint unsigned line;
      longint unsigned gaddr;
      longint unsigned idx;
      logic [7:0]      bits;
      for (int r = FIRST_ROW; r < ROWS_PER_CELL; r++) begin
         line  = longint'(y) + r;
         gaddr = longint'(code) * glyph_height_reg + r;
         idx   = longint'(x) + line * width_reg;
         bits  = (gaddr < FONT_DEPTH) ? font_mem[gaddr] : 8'h00;
         if (line >= height_reg) begin
            bits = 8'h00;
         end
         for (int k = 0; k < CELL_COLS; k++) begin
            if (longint'(x) + k >= width_reg) begin
               bits[CELL_COLS-1-k] = 1'b0;
            end
         end
         beat.index = idx[INDEX_W-1:0];
         beat.mask  = bits;
         beat.color = color;
         beat.last  = (r == ROWS_PER_CELL - 1);
         rows_due.push_back(beat);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         width_reg        = SCREEN_WIDTH_RESET;
         height_reg       = SCREEN_HEIGHT_RESET;
         glyph_height_reg = GLYPH_HEIGHT_RESET;
         rows_due.delete();
         mismatch_count = 0;
         beat_no        = 0;
      end else begin
         if (rsp_strobe) begin
            if (rows_due.size() == 0) begin
               report_mismatch("arrived with no row outstanding");
            end else begin
               want = rows_due.pop_front();
               if (rsp_row_base_index !== want.index) begin
                  report_mismatch($sformatf("row_base_index is %0h, expected %0h",
                                            rsp_row_base_index, want.index));
               end
               if (rsp_pixel_mask !== want.mask) begin
                  report_mismatch($sformatf("pixel_mask is %0h, expected %0h",
                                            rsp_pixel_mask, want.mask));
               end
               if (rsp_write_color !== want.color) begin
                  report_mismatch($sformatf("write_color is %0h, expected %0h",
                                            rsp_write_color, want.color));
               end
               if (rsp_last_row !== want.last) begin
                  report_mismatch($sformatf("last_row is %0b, expected %0b",
                                            rsp_last_row, want.last));
               end
            end
            beat_no++;
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               CSR_SCREEN_WIDTH: begin
                  width_reg = pwdata[SCREEN_W-1:0];
               end
               CSR_SCREEN_HEIGHT: begin
                  height_reg = pwdata[SCREEN_W-1:0];
               end
               CSR_GLYPH_HEIGHT: begin
                  glyph_height_reg = pwdata[GH_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (start && !busy) begin
            if (req_op == OP_DRAW) begin
               predict_draw_rows(req_cell_x, req_cell_y, req_ink_color, req_char_code);
            end else begin
               font_mem[req_font_addr] = req_font_byte;
            end
         end
      end
      rows_outstanding = rows_due.size();
   end

endmodule

[tb/sv/glyph_cell_blitter_tb.sv]
`timescale 1ns / 100ps
// Top of the glyph cell blitter testbench: clock, reset, font loads, draws and register writes.
// Depends on gcb_pkg, glyph_cell_blitter and glyph_row_checker.
module glyph_cell_blitter_tb;
   import gcb_pkg::*;

   localparam int FONT_DEPTH    = 8192;
   localparam int FIRST_ROW     = 2;
   localparam int ROWS_PER_CELL = 12;
   localparam int DRAIN_CYCLES  = 24;
   localparam int MAX_GAP       = 60;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_op;
   logic [FADDR_W-1:0]   req_font_addr;
   logic [7:0]           req_font_byte;
   logic [X_W-1:0]       req_cell_x;
   logic [X_W-1:0]       req_cell_y;
   logic [COLOR_W-1:0]   req_ink_color;
   logic [CODE_W-1:0]    req_char_code;
   logic                 rsp_strobe;
   logic [INDEX_W-1:0]   rsp_row_base_index;
   logic [CELL_COLS-1:0] rsp_pixel_mask;
   logic [COLOR_W-1:0]   rsp_write_color;
   logic                 rsp_last_row;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [PADDR_W-1:0]   paddr;
   logic [PDATA_W-1:0]   pwdata;
   logic [PDATA_W-1:0]   prdata;
   logic                 pready;
   int                   mismatch_count;
   int                   rows_outstanding;

   bit font_loaded [FONT_DEPTH];
   int stim_width  = 1024;
   int stim_height = 768;
   int stim_gh     = 16;
   int idle_pct    = 0;

   glyph_cell_blitter dut (.*);

   glyph_row_checker row_check (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic issue(input logic op, input logic [FADDR_W-1:0] faddr,
                        input logic [7:0] fbyte, input logic [X_W-1:0] x,
                        input logic [X_W-1:0] y, input logic [COLOR_W-1:0] color,
                        input logic [CODE_W-1:0] code);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         <= 1'b1;
      req_op        <= op;
      req_font_addr <= faddr;
      req_font_byte <= fbyte;
      req_cell_x    <= x;
      req_cell_y    <= y;
      req_ink_color <= color;
      req_char_code <= code;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic load_font(input int addr, input logic [7:0] fbyte);
      issue(OP_LOAD, FADDR_W'(addr), fbyte, X_W'($urandom), X_W'($urandom), $urandom,
            CODE_W'($urandom));
      font_loaded[addr] = 1'b1;
   endtask

   // Every glyph byte a draw will read is loaded first; bytes past the store read as blank.
   task automatic draw_glyph(input logic [X_W-1:0] x, input logic [X_W-1:0] y,
                             input logic [COLOR_W-1:0] color, input logic [CODE_W-1:0] code);
      int addr;
      for (int r = FIRST_ROW; r < ROWS_PER_CELL; r++) begin
         addr = int'(code) * stim_gh + r;
         if (addr < FONT_DEPTH && !font_loaded[addr]) begin
            load_font(addr, 8'($urandom));
         end
      end
      issue(OP_DRAW, FADDR_W'($urandom), 8'($urandom), x, y, color, code);
   endtask

   task automatic draw_random();
      logic [X_W-1:0]    x;
      logic [X_W-1:0]    y;
      logic [CODE_W-1:0] code;
      if ($urandom_range(3) == 0) begin
         x = X_W'($urandom_range(65535));
         y = X_W'($urandom_range(65535));
      end else begin
         x = X_W'($urandom_range(stim_width + 8));
         y = X_W'($urandom_range(stim_height + 12));
      end
      code = ($urandom_range(3) == 0) ? CODE_W'($urandom_range(255)) : CODE_W'($urandom_range(7));
      draw_glyph(x, y, $urandom, code);
   endtask

   task automatic wait_idle(input int extra);
      start <= 1'b0;
      @(negedge clock);
      while (rows_outstanding != 0) begin
         @(negedge clock);
      end
      repeat (extra) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] reg_sel, input int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(input int width, input int height, input int gh, input int pct);
      wait_idle(DRAIN_CYCLES);
      csr_write(CSR_SCREEN_WIDTH, width);
      csr_write(CSR_SCREEN_HEIGHT, height);
      csr_write(CSR_GLYPH_HEIGHT, gh);
      stim_width  = width;
      stim_height = height;
      stim_gh     = gh;
      idle_pct    = pct;
   endtask

   task automatic random_traffic(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(14) == 0) begin
            wait_idle(0);
         end
         if ($urandom_range(5) == 0) begin
            load_font($urandom_range(FONT_DEPTH - 1), 8'($urandom));
         end else begin
            draw_random();
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_op        = OP_LOAD;
      req_font_addr = '0;
      req_font_byte = '0;
      req_cell_x    = '0;
      req_cell_y    = '0;
      req_ink_color = '0;
      req_char_code = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      load_font(FONT_DEPTH - 1, 8'hFF);
      load_font(0, 8'h00);
      draw_glyph(16'd0, 16'd0, 32'h0000_0000, 8'd0);
      draw_glyph(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'd255);
      for (int r = FIRST_ROW; r < ROWS_PER_CELL; r++) begin
         load_font(stim_gh + r, (r % 2 == 0) ? 8'hFF : 8'h81);
      end
      draw_glyph(16'd1021, 16'd5, 32'h5A5A_5A5A, 8'd1);
      draw_glyph(16'd8, 16'd760, 32'hA5A5_A5A5, 8'd1);
      draw_glyph(16'd300, 16'd200, 32'h1234_5678, 8'd128);

      configure(1, 1, 1, 0);
      draw_glyph(16'd0, 16'd0, 32'hFFFF_FFFF, 8'd3);
      random_traffic(2);

      // Widest screen: the base index wraps and high codes fall past the glyph store.
      configure(8191, 8191, 63, 88);
      draw_glyph(16'hFFFF, 16'hFFFF, 32'hDEAD_BEEF, 8'd255);
      draw_glyph(16'd8180, 16'd8185, 32'h0F0F_0F0F, 8'd130);
      random_traffic(3);

      configure(0, 0, 32, 34);
      random_traffic(2);

      configure($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 32), 0);
      random_traffic(2);

      configure($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 32), 88);
      random_traffic(2);

      configure(4096, 4096, 32, 34);
      random_traffic(2);

      wait_idle(DRAIN_CYCLES);
      if (mismatch_count == 0 && rows_outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/gcb_pkg.sv
rtl/gcb_ram.sv
rtl/glyph_cell_blitter.sv
tb/sv/glyph_row_checker.sv
tb/sv/glyph_cell_blitter_tb.sv
